FILE: design/gtea_pkg.sv
// Package for the grant table entry allocator: field widths, flag masks,
// command codes, controller states and controller/datapath structs.
// No dependencies.
`default_nettype none

package gtea_pkg;

  // Default table depth
  localparam int ENTRIES_DEF = 1024;

  // Fixed payload widths
  localparam int REF_W   = 10;
  localparam int DOM_W   = 16;
  localparam int FRAME_W = 32;
  localparam int FLAG_W  = 5;

  // Entry flag masks
  localparam logic [FLAG_W-1:0] FLAG_PERMIT   = 5'b00001;
  localparam logic [FLAG_W-1:0] FLAG_TRANSFER = 5'b00010;
  localparam logic [FLAG_W-1:0] FLAG_RDONLY   = 5'b00100;
  localparam logic [FLAG_W-1:0] FLAG_READING  = 5'b01000;
  localparam logic [FLAG_W-1:0] FLAG_WRITING  = 5'b10000;

  localparam int READING_BIT = 3;
  localparam int WRITING_BIT = 4;

  typedef enum logic [2:0] {
    CMD_GRANT_ACCESS    = 3'd0,
    CMD_GRANT_TRANSFER  = 3'd1,
    CMD_ACCESS_AT_REF   = 3'd2,
    CMD_TRANSFER_AT_REF = 3'd3,
    CMD_QUERY           = 3'd4,
    CMD_END_ACCESS      = 3'd5,
    CMD_FREE            = 3'd6,
    CMD_REMOTE_MARK     = 3'd7
  } command_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_en;  // write one reset entry of the sweep
    logic load;      // capture item, read link and flags
    logic commit;    // apply the command, load the result register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // sweep is at the final entry
  } ctl_sts_t;

endpackage

`default_nettype wire

FILE: design/gtea_if.sv
// Request and response channels of the grant table entry allocator.
// Depends on gtea_pkg.
`default_nettype none

interface gtea_in_if import gtea_pkg::*; ();
  logic                valid;
  logic                ready;
  command_t            command;
  logic [REF_W-1:0]    entry_ref;
  logic [DOM_W-1:0]    domain_id;
  logic [FRAME_W-1:0]  frame_number;
  logic                read_only;
  logic                remote_reading;
  logic                remote_writing;

  modport source (
    output valid, command, entry_ref, domain_id, frame_number,
           read_only, remote_reading, remote_writing,
    input  ready
  );
  modport sink (
    input  valid, command, entry_ref, domain_id, frame_number,
           read_only, remote_reading, remote_writing,
    output ready
  );
endinterface

interface gtea_out_if import gtea_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             status;
  logic [REF_W-1:0] granted_ref;
  logic             in_use_reading;
  logic             in_use_writing;
  logic             still_in_use;

  modport source (
    output valid, status, granted_ref, in_use_reading, in_use_writing, still_in_use,
    input  ready
  );
  modport sink (
    input  valid, status, granted_ref, in_use_reading, in_use_writing, still_in_use,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/gtea_ctrl.sv
// Controller of the grant table entry allocator: reset sweep, item
// handshake and result register valid. Depends on gtea_pkg.
`default_nettype none

module gtea_ctrl import gtea_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next   = state;
    cmd.clear_en = 1'b0;
    cmd.load     = 1'b0;
    cmd.commit   = 1'b0;
    in_ready     = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_en = !rst;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for room in the result register before touching state
        if (out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: design/gtea_dpath.sv
// Datapath of the grant table entry allocator: free list head, link and
// entry memories, item registers and result register. Depends on gtea_pkg.
`default_nettype none

module gtea_dpath import gtea_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ctl_cmd_t           cmd,
  output ctl_sts_t                sts,
  // item fields
  input  wire command_t           command,
  input  wire logic [REF_W-1:0]   entry_ref,
  input  wire logic [DOM_W-1:0]   domain_id,
  input  wire logic [FRAME_W-1:0] frame_number,
  input  wire logic               read_only,
  input  wire logic               remote_reading,
  input  wire logic               remote_writing,
  // result fields
  output logic                    status,
  output logic [REF_W-1:0]        granted_ref,
  output logic                    in_use_reading,
  output logic                    in_use_writing,
  output logic                    still_in_use
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;  // entry index
  localparam int LW = $clog2(ENTRIES + 1);                  // link, ENTRIES = end
  localparam int CW = (LW > REF_W) ? LW : REF_W;            // range compare

  // Memories
  logic [LW-1:0]      free_next   [ENTRIES];
  logic [FLAG_W-1:0]  entry_flags [ENTRIES];
  logic [FRAME_W-1:0] entry_frame [ENTRIES];
  logic [DOM_W-1:0]   entry_domain[ENTRIES];

  logic [LW-1:0] free_head;
  logic [IW-1:0] clr_idx;

  // Captured item and read data
  command_t           it_cmd;
  logic [REF_W-1:0]   it_ref;
  logic [DOM_W-1:0]   it_dom;
  logic [FRAME_W-1:0] it_frame;
  logic               it_ro;
  logic               it_rr;
  logic               it_rw;
  logic [LW-1:0]      next_rd;
  logic [FLAG_W-1:0]  flags_rd;

  // Decode
  logic              is_grant;
  logic              is_fill_ref;
  logic              is_push;
  logic              list_empty;
  logic              ref_ok;
  logic              grant_ok;
  logic              fill_en;
  logic [IW-1:0]     ref_idx;
  logic [IW-1:0]     head_idx;
  logic [IW-1:0]     fill_idx;
  logic [FLAG_W-1:0] fill_flags;
  logic [FLAG_W-1:0] mark_flags;

  logic              flags_we;
  logic [IW-1:0]     flags_wa;
  logic [FLAG_W-1:0] flags_wd;
  logic              next_we;
  logic [IW-1:0]     next_wa;
  logic [LW-1:0]     next_wd;

  assign sts.clear_last = (clr_idx == IW'(ENTRIES - 1));

  // Reset sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (cmd.clear_en && !sts.clear_last) begin
      clr_idx <= clr_idx + IW'(1);
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_cmd   <= command;
      it_ref   <= entry_ref;
      it_dom   <= domain_id;
      it_frame <= frame_number;
      it_ro    <= read_only;
      it_rr    <= remote_reading;
      it_rw    <= remote_writing;
    end
  end

  assign is_grant    = (it_cmd == CMD_GRANT_ACCESS) || (it_cmd == CMD_GRANT_TRANSFER);
  assign is_fill_ref = (it_cmd == CMD_ACCESS_AT_REF) || (it_cmd == CMD_TRANSFER_AT_REF);
  assign is_push     = (it_cmd == CMD_END_ACCESS) || (it_cmd == CMD_FREE);
  assign list_empty  = (free_head == LW'(ENTRIES));
  assign ref_ok      = (CW'(it_ref) < CW'(ENTRIES));
  assign grant_ok    = is_grant && !list_empty;
  assign fill_en     = grant_ok || (ref_ok && is_fill_ref);
  assign ref_idx     = IW'(it_ref);
  assign head_idx    = IW'(free_head);
  assign fill_idx    = is_grant ? head_idx : ref_idx;

  assign fill_flags = ((it_cmd == CMD_GRANT_ACCESS) || (it_cmd == CMD_ACCESS_AT_REF))
                      ? (FLAG_PERMIT | (it_ro ? FLAG_RDONLY : '0))
                      : FLAG_TRANSFER;
  assign mark_flags = (flags_rd & ~(FLAG_READING | FLAG_WRITING))
                      | (it_rr ? FLAG_READING : '0) | (it_rw ? FLAG_WRITING : '0);

  // Flag memory write port
  always_comb begin
    flags_we = 1'b0;
    flags_wa = fill_idx;
    flags_wd = fill_flags;
    if (cmd.clear_en) begin
      flags_we = 1'b1;
      flags_wa = clr_idx;
      flags_wd = '0;
    end else if (cmd.commit) begin
      if (fill_en) begin
        flags_we = 1'b1;
      end else if (ref_ok && (it_cmd == CMD_END_ACCESS)) begin
        flags_we = 1'b1;
        flags_wa = ref_idx;
        flags_wd = '0;
      end else if (ref_ok && (it_cmd == CMD_REMOTE_MARK)) begin
        flags_we = 1'b1;
        flags_wa = ref_idx;
        flags_wd = mark_flags;
      end
    end
  end

  // Link memory write port
  always_comb begin
    next_we = 1'b0;
    next_wa = ref_idx;
    next_wd = free_head;
    if (cmd.clear_en) begin
      next_we = 1'b1;
      next_wa = clr_idx;
      next_wd = LW'(clr_idx) + LW'(1);
    end else if (cmd.commit && ref_ok && is_push) begin
      next_we = 1'b1;
    end
  end

  // Flags and link memories, registered reads at item capture
  always_ff @(posedge clk) begin
    if (flags_we) begin
      entry_flags[flags_wa] <= flags_wd;
    end
    if (next_we) begin
      free_next[next_wa] <= next_wd;
    end
    if (cmd.load) begin
      flags_rd <= entry_flags[IW'(entry_ref)];
      next_rd  <= free_next[head_idx];
    end
  end

  // Frame and domain store
  always_ff @(posedge clk) begin
    if (cmd.commit && fill_en) begin
      entry_frame[fill_idx]  <= it_frame;
      entry_domain[fill_idx] <= it_dom;
    end
  end

  // Free list head
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
    end else if (cmd.commit) begin
      if (grant_ok) begin
        free_head <= next_rd;
      end else if (ref_ok && is_push) begin
        free_head <= LW'(it_ref);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status         <= is_grant && list_empty;
      granted_ref    <= grant_ok ? REF_W'(free_head) : '0;
      in_use_reading <= ref_ok && ((it_cmd == CMD_QUERY) || (it_cmd == CMD_END_ACCESS))
                        && flags_rd[READING_BIT];
      in_use_writing <= ref_ok && ((it_cmd == CMD_QUERY) || (it_cmd == CMD_END_ACCESS))
                        && flags_rd[WRITING_BIT];
      still_in_use   <= ref_ok && (it_cmd == CMD_END_ACCESS)
                        && (flags_rd[READING_BIT] || flags_rd[WRITING_BIT]);
    end
  end

endmodule

`default_nettype wire

FILE: design/grant_table_entry_allocator.sv
// Grant table entry allocator, top level: ties the controller to the
// datapath and the request/response channels. Depends on gtea_pkg, gtea_if,
// gtea_ctrl and gtea_dpath.
//
// Each item is one command on a table of ENTRIES grant entries with a linked
// free list, and gives exactly one result item. On accept, the block reads the
// head's link and the addressed entry's flags from the single-port link and flag
// memories; the execute state then writes them back and loads the result
// register once that register has room. A new item is taken the cycle after
// that, even while the previous result waits; the write-back of that next item
// then stretches until the waiting result is taken. After reset the block
// sweeps the link and flag memories to their start values, with ready low.
`default_nettype none

module grant_table_entry_allocator import gtea_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  gtea_in_if.sink    req,
  gtea_out_if.source rsp
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  gtea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (ctl)
  );

  gtea_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (ctl),
    .sts            (sts),
    .command        (req.command),
    .entry_ref      (req.entry_ref),
    .domain_id      (req.domain_id),
    .frame_number   (req.frame_number),
    .read_only      (req.read_only),
    .remote_reading (req.remote_reading),
    .remote_writing (req.remote_writing),
    .status         (rsp.status),
    .granted_ref    (rsp.granted_ref),
    .in_use_reading (rsp.in_use_reading),
    .in_use_writing (rsp.in_use_writing),
    .still_in_use   (rsp.still_in_use)
  );

endmodule

`default_nettype wire

FILE: design/gtea_checker.sv
// Port checker for the grant table entry allocator and its bind.
// Depends on gtea_pkg and grant_table_entry_allocator.
`default_nettype none

module gtea_checker import gtea_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic             status,
  input wire logic [REF_W-1:0] granted_ref,
  input wire logic             in_use_reading,
  input wire logic             in_use_writing,
  input wire logic             still_in_use
);

  // reset starts the memory sweep, so no item is taken right after it
  a_ready_low_after_reset: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("ready high right after reset");

  // one item at a time: no accept in the cycle after an accept
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while previous item still at work");

  // a result that is not taken stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");

  // a failed grant reports nothing else
  a_no_space_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |->
      (granted_ref == '0) && !still_in_use && !in_use_reading && !in_use_writing)
    else $error("no_space result carries other fields");

  // still in use only follows from a remote mark
  a_still_in_use_marks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && still_in_use) |-> (in_use_reading || in_use_writing))
    else $error("still_in_use without a remote mark");

endmodule

bind grant_table_entry_allocator gtea_checker u_gtea_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (req.valid),
  .in_ready       (req.ready),
  .out_valid      (rsp.valid),
  .out_ready      (rsp.ready),
  .status         (rsp.status),
  .granted_ref    (rsp.granted_ref),
  .in_use_reading (rsp.in_use_reading),
  .in_use_writing (rsp.in_use_writing),
  .still_in_use   (rsp.still_in_use)
);

`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking bench for grant_table_entry_allocator: a queued driver, a
// response monitor and a command-level model of the table and free list.
// Depends on gtea_pkg, gtea_if and the allocator RTL.
`timescale 1ns / 100ps

module tb_top;
  import gtea_pkg::*;

  localparam int TABLE_DEPTH   = ENTRIES_DEF;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUEUE_AHEAD   = 4;

  typedef struct {
    command_t             op;
    logic [REF_W-1:0]     slot;
    logic [DOM_W-1:0]     domain;
    logic [FRAME_W-1:0]   frame;
    logic                 ro;
    logic                 rd;
    logic                 wr;
  } grant_cmd_t;

  typedef struct packed {
    logic             status;
    logic [REF_W-1:0] granted;
    logic             reading;
    logic             writing;
    logic             busy;
  } grant_reply_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_QUARTER,
    RDY_LONG_HOLD
  } rdy_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycle_count = 0;
  int   error_count = 0;

  gtea_in_if  req_if ();
  gtea_out_if rsp_if ();

  grant_table_entry_allocator #(
    .ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Commands waiting to be driven, and replies the model has predicted
  grant_cmd_t   cmd_queue[$];
  grant_reply_t predicted_replies[$];

  // Model state: free list head and links, entry flags
  logic [10:0]       model_head;
  logic [10:0]       model_link [TABLE_DEPTH];
  logic [FLAG_W-1:0] model_flags [TABLE_DEPTH];

  // Entries currently handed out, and those with an end or free already queued
  logic [REF_W-1:0] held_slots[$];
  bit               claimed [TABLE_DEPTH];

  task automatic release_slot(input logic [REF_W-1:0] slot);
    foreach (held_slots[i]) begin
      if (held_slots[i] == slot) begin
        held_slots.delete(i);
        break;
      end
    end
  endtask

  task automatic push_free(input logic [REF_W-1:0] slot);
    model_link[slot] = model_head;
    model_head       = {1'b0, slot};
    release_slot(slot);
  endtask

  // Apply one command to the model and return its reply
  task automatic apply_command(input grant_cmd_t c, output grant_reply_t r);
    logic [10:0]       h;
    logic [FLAG_W-1:0] access_fl;
    access_fl = FLAG_PERMIT | (c.ro ? FLAG_RDONLY : '0);
    r = '0;
    if (c.op == CMD_GRANT_ACCESS || c.op == CMD_GRANT_TRANSFER) begin
      if (model_head >= TABLE_DEPTH) begin
        r.status = 1'b1;
      end else begin
        h             = model_head;
        model_head    = model_link[h];
        model_flags[h] = (c.op == CMD_GRANT_ACCESS) ? access_fl : FLAG_TRANSFER;
        r.granted     = h[REF_W-1:0];
        held_slots.push_back(h[REF_W-1:0]);
        claimed[h]    = 1'b0;
      end
    end else if (c.slot < TABLE_DEPTH) begin
      case (c.op)
        CMD_ACCESS_AT_REF:   model_flags[c.slot] = access_fl;
        CMD_TRANSFER_AT_REF: model_flags[c.slot] = FLAG_TRANSFER;
        CMD_QUERY: begin
          r.reading = model_flags[c.slot][READING_BIT];
          r.writing = model_flags[c.slot][WRITING_BIT];
        end
        CMD_END_ACCESS: begin
          r.reading = model_flags[c.slot][READING_BIT];
          r.writing = model_flags[c.slot][WRITING_BIT];
          r.busy    = r.reading | r.writing;
          model_flags[c.slot] = '0;
          push_free(c.slot);
        end
        CMD_FREE: push_free(c.slot);
        default: begin
          model_flags[c.slot] = (model_flags[c.slot] & ~(FLAG_READING | FLAG_WRITING)) |
                                (c.rd ? FLAG_READING : '0) | (c.wr ? FLAG_WRITING : '0);
        end
      endcase
    end
  endtask

  // Driver: bursts of items with random gaps
  grant_cmd_t   drv_cmd;
  grant_reply_t drv_reply;
  int           burst_left = 0;
  int           gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        apply_command(drv_cmd, drv_reply);
        predicted_replies.push_back(drv_reply);
      end
      if (!req_if.valid || req_if.ready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          req_if.valid <= 1'b0;
        end else if (cmd_queue.size() > 0) begin
          drv_cmd = cmd_queue.pop_front();
          req_if.valid          <= 1'b1;
          req_if.command        <= drv_cmd.op;
          req_if.entry_ref      <= drv_cmd.slot;
          req_if.domain_id      <= drv_cmd.domain;
          req_if.frame_number   <= drv_cmd.frame;
          req_if.read_only      <= drv_cmd.ro;
          req_if.remote_reading <= drv_cmd.rd;
          req_if.remote_writing <= drv_cmd.wr;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left = burst_left - 1;
          end
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready pattern in randomly chosen, changing modes
  rdy_mode_t rdy_mode  = RDY_ALWAYS;
  int        mode_left = 0;
  int        hold_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
      mode_left = 0;
      hold_left = 0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end else begin
        mode_left = mode_left - 1;
      end
      case (rdy_mode)
        RDY_ALWAYS:  rsp_if.ready <= 1'b1;
        RDY_COIN:    rsp_if.ready <= 1'($urandom_range(0, 1));
        RDY_QUARTER: rsp_if.ready <= (cycle_count % 4 == 0);
        default: begin
          if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_if.ready <= 1'b0;
          end else if ($urandom_range(0, 15) == 0) begin
            hold_left = $urandom_range(3, 12);
            rsp_if.ready <= 1'b0;
          end else begin
            rsp_if.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Monitor: compare each reply with the oldest prediction
  grant_reply_t mon_got;
  grant_reply_t mon_want;

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      mon_got = {rsp_if.status, rsp_if.granted_ref, rsp_if.in_use_reading,
                 rsp_if.in_use_writing, rsp_if.still_in_use};
      if (predicted_replies.size() == 0) begin
        $display("%0t: unexpected reply, expected none, actual %p", $time, mon_got);
        error_count++;
      end else begin
        mon_want = predicted_replies.pop_front();
        check_field("status", int'(mon_want.status), int'(mon_got.status));
        check_field("granted_ref", int'(mon_want.granted), int'(mon_got.granted));
        check_field("in_use_reading", int'(mon_want.reading), int'(mon_got.reading));
        check_field("in_use_writing", int'(mon_want.writing), int'(mon_got.writing));
        check_field("still_in_use", int'(mon_want.busy), int'(mon_got.busy));
      end
    end
  end

  function automatic grant_cmd_t fixed_cmd(input command_t op, input logic [REF_W-1:0] slot,
                                           input logic [DOM_W-1:0] domain,
                                           input logic [FRAME_W-1:0] frame,
                                           input logic ro, input logic rd, input logic wr);
    grant_cmd_t c;
    c.op = op;  c.slot = slot;  c.domain = domain;  c.frame = frame;
    c.ro = ro;  c.rd = rd;      c.wr = wr;
    return c;
  endfunction

  function automatic grant_cmd_t make_cmd(input command_t op, input logic [REF_W-1:0] slot);
    return fixed_cmd(op, slot, DOM_W'($urandom_range(0, 65535)), FRAME_W'($urandom),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
  endfunction

  function automatic command_t grant_op();
    return $urandom_range(0, 1) ? CMD_GRANT_TRANSFER : CMD_GRANT_ACCESS;
  endfunction

  function automatic bit pick_held(output logic [REF_W-1:0] slot);
    int idx;
    slot = '0;
    if (held_slots.size() == 0) return 1'b0;
    for (int t = 0; t < 8; t++) begin
      idx = $urandom_range(0, held_slots.size() - 1);
      if (!claimed[held_slots[idx]]) begin
        slot = held_slots[idx];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic push_cmd(input grant_cmd_t c);
    while (cmd_queue.size() >= QUEUE_AHEAD) @(negedge clk);
    cmd_queue.push_back(c);
  endtask

  task automatic push_grant();
    push_cmd(make_cmd(grant_op(), REF_W'($urandom_range(0, TABLE_DEPTH - 1))));
  endtask

  task automatic mark_and_query(input logic [REF_W-1:0] slot);
    push_cmd(make_cmd(CMD_REMOTE_MARK, slot));
    push_cmd(make_cmd(CMD_QUERY, slot));
  endtask

  // End or free a held entry, claiming it so it is not returned twice
  task automatic retire_slot(input logic [REF_W-1:0] slot);
    claimed[slot] = 1'b1;
    push_cmd(make_cmd($urandom_range(0, 2) != 0 ? CMD_END_ACCESS : CMD_FREE, slot));
  endtask

  task automatic wait_quiet();
    while (cmd_queue.size() != 0 || req_if.valid || predicted_replies.size() != 0)
      @(negedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    logic [REF_W-1:0] slot;
    int               pick;

    req_if.valid          = 1'b0;
    req_if.command        = CMD_GRANT_ACCESS;
    req_if.entry_ref      = '0;
    req_if.domain_id      = '0;
    req_if.frame_number   = '0;
    req_if.read_only      = 1'b0;
    req_if.remote_reading = 1'b0;
    req_if.remote_writing = 1'b0;
    rsp_if.ready          = 1'b0;
    model_head = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      model_link[i]  = 11'(i + 1);
      model_flags[i] = '0;
      claimed[i]     = 1'b0;
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, every command, marks seen by query and end
    push_cmd(fixed_cmd(CMD_GRANT_ACCESS, 0, 16'h0000, 32'h0000_0000, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_GRANT_TRANSFER, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 1, 1, 1));
    push_cmd(fixed_cmd(CMD_GRANT_ACCESS, 0, 16'h1234, 32'h8000_0001, 1, 0, 0));
    push_cmd(fixed_cmd(CMD_ACCESS_AT_REF, 10'h3FF, 16'hFFFF, 32'hFFFF_FFFF, 1, 0, 0));
    push_cmd(fixed_cmd(CMD_TRANSFER_AT_REF, 0, 16'h0000, 32'h0000_0000, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_REMOTE_MARK, 0, 0, 0, 0, 1, 0));
    push_cmd(fixed_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_REMOTE_MARK, 0, 0, 0, 0, 0, 1));
    push_cmd(fixed_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_REMOTE_MARK, 0, 0, 0, 0, 1, 1));
    push_cmd(fixed_cmd(CMD_END_ACCESS, 0, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_REMOTE_MARK, 10'h3FF, 0, 0, 0, 1, 1));
    push_cmd(fixed_cmd(CMD_QUERY, 10'h3FF, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_REMOTE_MARK, 10'h3FF, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_END_ACCESS, 1, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_FREE, 2, 0, 0, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_GRANT_ACCESS, 0, 16'hFFFF, 32'h0000_0000, 1, 0, 0));
    push_cmd(fixed_cmd(CMD_GRANT_TRANSFER, 0, 16'h0000, 32'hFFFF_FFFF, 0, 0, 0));
    push_cmd(fixed_cmd(CMD_GRANT_ACCESS, 0, 16'h5A5A, 32'hA5A5_A5A5, 0, 0, 0));

    // Hold the sender until every reply is back
    wait_quiet();

    // Drain the free list, with marks and queries on handed-out entries
    for (int n = 0; n < 1080; n++) begin
      if ($urandom_range(0, 19) == 0 && pick_held(slot)) mark_and_query(slot);
      else push_grant();
    end

    // Churn around an empty list: grants compete with ends and frees
    for (int n = 0; n < 250; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        push_grant();
      end else if (pick_held(slot)) begin
        if (pick < 8) retire_slot(slot);
        else mark_and_query(slot);
      end else begin
        push_grant();
      end
    end

    // Double free of a handed-out entry; it is then handed out twice
    if (!pick_held(slot)) slot = '0;
    push_cmd(make_cmd(CMD_FREE, slot));
    push_cmd(make_cmd(CMD_FREE, slot));
    push_cmd(make_cmd(CMD_GRANT_ACCESS, slot));
    push_cmd(make_cmd(CMD_GRANT_TRANSFER, slot));

    // Mixed traffic: sequences on held entries plus noise on any entry
    for (int n = 0; n < 360; n++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        push_cmd(make_cmd(command_t'($urandom_range(0, 7)),
                          REF_W'($urandom_range(0, TABLE_DEPTH - 1))));
      end else if (pick < 6) begin
        push_grant();
      end else if (pick_held(slot)) begin
        mark_and_query(slot);
        if ($urandom_range(0, 1)) retire_slot(slot);
      end else begin
        push_cmd(make_cmd(command_t'($urandom_range(0, 7)),
                          REF_W'($urandom_range(0, TABLE_DEPTH - 1))));
      end
    end

    wait_quiet();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("grant_table_entry_allocator verification clean");
    end else begin
      $display("grant_table_entry_allocator verification failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(negedge clk);
    $display("grant_table_entry_allocator verification failed");
    $finish;
  end

endmodule
